>>> hdl/i2cbm_pkg.sv
// Shared types and constants for the I2C bit-level master.
package i2cbm_pkg;

    // Bits in one data byte on the bus
    localparam int unsigned BITS_PER_BYTE = 8;

    // Command codes
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Configuration register indexes
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    // Configuration reset values
    localparam logic [7:0] HALF_PERIOD_RESET = 8'd2;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    // Bus sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_A  = 4'd1,
        PH_START_B  = 4'd2,
        PH_STOP_A   = 4'd3,
        PH_STOP_B   = 4'd4,
        PH_WR_LOW   = 4'd5,
        PH_WR_HIGH  = 4'd6,
        PH_ACK_LOW  = 4'd7,
        PH_ACK_WAIT = 4'd8,
        PH_RD_LOW   = 4'd9,
        PH_RD_HIGH  = 4'd10,
        PH_RA_LOW   = 4'd11,
        PH_RA_HIGH  = 4'd12
    } phase_t;

    // One tick item as taken from the input channel
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_sample;
    } tick_item_t;

    // One result item for the output channel
    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       nack_seen;
    } tick_result_t;

    // Configuration as seen by the sequencer
    typedef struct packed {
        logic [7:0] half_period_ticks;
        logic [7:0] ack_timeout_limit;
    } bus_cfg_t;

endpackage

>>> hdl/i2cbm_if.sv
// Valid/ready channel interfaces for tick items and result items.
interface i2cbm_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_sample;

    modport source (output valid, output cmd, output write_data, output send_ack,
                    output sda_sample, input ready);
    modport sink (input valid, input cmd, input write_data, input send_ack,
                  input sda_sample, output ready);
endinterface

interface i2cbm_result_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nack_seen;

    modport source (output valid, output scl_level, output sda_pull_low,
                    output busy_res, output done_res, output read_data,
                    output nack_seen, input ready);
    modport sink (input valid, input scl_level, input sda_pull_low, input busy_res,
                  input done_res, input read_data, input nack_seen, output ready);
endinterface

>>> hdl/i2c_bit_level_master.sv
// Top level of the I2C bit-level master: channel staging and configuration.
//
//   channel   dir  transfer   payload
//   item      in   one tick   cmd, write_data, send_ack, sda_sample
//   result    out  one tick   scl_level, sda_pull_low, busy_res, done_res,
//                             read_data, nack_seen
//   cfg_*     in   write      cfg_index selects register, cfg_data value
//
// One tick item per clock sustained while the result channel is ready; a result passes
// through the input register, then one sequencer step into the result register.
// Reset clears the sequencer to idle with both lines released and loads the
// configuration defaults. A stalled result holds its register; the input stage
// keeps taking items until it is full as well.
module i2c_bit_level_master
(
    input  logic                  clk,
    input  logic                  rst_n,
    i2cbm_item_if.sink            item,
    i2cbm_result_if.source        result,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [7:0]            cfg_data
);

    logic                     item_valid_reg;
    i2cbm_pkg::tick_item_t    item_reg;
    logic                     res_valid_reg;
    i2cbm_pkg::tick_result_t  res_reg;
    i2cbm_pkg::tick_result_t  step_result;
    i2cbm_pkg::bus_cfg_t      cfg_reg;
    logic                     advance;

    // Step when a tick is staged and the result slot is free or draining
    assign advance    = item_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks <= i2cbm_pkg::HALF_PERIOD_RESET;
            cfg_reg.ack_timeout_limit <= i2cbm_pkg::ACK_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i2cbm_pkg::CFG_HALF_PERIOD: cfg_reg.half_period_ticks <= cfg_data;
                i2cbm_pkg::CFG_ACK_TIMEOUT: cfg_reg.ack_timeout_limit <= cfg_data;
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (item.ready)
            item_valid_reg <= item.valid;
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg.cmd        <= item.cmd;
            item_reg.write_data <= item.write_data;
            item_reg.send_ack   <= item.send_ack;
            item_reg.sda_sample <= item.sda_sample;
        end
    end

    i2cbm_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .cfg    (cfg_reg),
        .item   (item_reg),
        .result (step_result)
    );

    // Result stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= advance || (res_valid_reg && !result.ready);
    end

    // Result stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= step_result;
    end

    // Drive the result channel
    assign result.valid        = res_valid_reg;
    assign result.scl_level    = res_reg.scl_level;
    assign result.sda_pull_low = res_reg.sda_pull_low;
    assign result.busy_res     = res_reg.busy_res;
    assign result.done_res     = res_reg.done_res;
    assign result.read_data    = res_reg.read_data;
    assign result.nack_seen    = res_reg.nack_seen;

endmodule

>>> hdl/i2cbm_seq.sv
// Bus sequencer: holds the I2C phase state and advances it by one tick.
module i2cbm_seq
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  i2cbm_pkg::bus_cfg_t      cfg,
    input  i2cbm_pkg::tick_item_t    item,
    output i2cbm_pkg::tick_result_t  result
);

    i2cbm_pkg::phase_t phase_reg, phase_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [8:0] tick_count_reg, tick_count_next;
    logic [7:0] ack_wait_count_reg, ack_wait_count_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       ack_choice_reg, ack_choice_next;
    logic       nack_flag_reg, nack_flag_next;
    logic [7:0] read_hold_reg, read_hold_next;
    logic       done_next;

    logic [7:0] half_len;
    logic [8:0] hold_len;
    logic [8:0] tick_inc;
    logic [3:0] bit_inc;
    logic       ended;

    // Half period with zero treated as one; start and stop hold twice as long
    always_comb
    begin
        half_len = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
        if (phase_reg inside {i2cbm_pkg::PH_START_A, i2cbm_pkg::PH_START_B,
                              i2cbm_pkg::PH_STOP_A, i2cbm_pkg::PH_STOP_B})
            hold_len = {half_len, 1'b0};
        else
            hold_len = {1'b0, half_len};
        tick_inc = tick_count_reg + 9'd1;
        bit_inc  = bit_count_reg + 4'd1;
    end

    // Next state for one tick
    always_comb
    begin
        phase_next          = phase_reg;
        bit_count_next      = bit_count_reg;
        tick_count_next     = tick_count_reg;
        ack_wait_count_next = ack_wait_count_reg;
        shift_byte_next     = shift_byte_reg;
        scl_next            = scl_reg;
        sda_next            = sda_reg;
        ack_choice_next     = ack_choice_reg;
        nack_flag_next      = nack_flag_reg;
        read_hold_next      = read_hold_reg;
        done_next           = 1'b0;
        ended               = 1'b0;

        if (phase_reg == i2cbm_pkg::PH_IDLE)
        begin
            case (item.cmd)
                i2cbm_pkg::CMD_START:
                begin
                    phase_next = i2cbm_pkg::PH_START_A;
                    scl_next = 1'b1; sda_next = 1'b1; tick_count_next = '0;
                end
                i2cbm_pkg::CMD_STOP:
                begin
                    phase_next = i2cbm_pkg::PH_STOP_A;
                    scl_next = 1'b0; sda_next = 1'b0; tick_count_next = '0;
                end
                i2cbm_pkg::CMD_WRITE:
                begin
                    nack_flag_next  = 1'b0;
                    bit_count_next  = '0;
                    shift_byte_next = {item.write_data[6:0], 1'b0};
                    phase_next = i2cbm_pkg::PH_WR_LOW;
                    scl_next = 1'b0; sda_next = item.write_data[7]; tick_count_next = '0;
                end
                i2cbm_pkg::CMD_READ:
                begin
                    ack_choice_next = item.send_ack;
                    bit_count_next  = '0;
                    shift_byte_next = '0;
                    phase_next = i2cbm_pkg::PH_RD_LOW;
                    scl_next = 1'b0; sda_next = 1'b1; tick_count_next = '0;
                end
                default:
                begin
                    phase_next = i2cbm_pkg::PH_IDLE;
                end
            endcase
        end
        else if (phase_reg == i2cbm_pkg::PH_ACK_WAIT)
        begin
            // Wait for ACK low while SCL is high, give up at the limit
            if (!item.sda_sample)
            begin
                scl_next   = 1'b0;
                phase_next = i2cbm_pkg::PH_IDLE;
                done_next  = 1'b1;
            end
            else if (ack_wait_count_reg >= cfg.ack_timeout_limit)
            begin
                nack_flag_next = 1'b1;
                phase_next = i2cbm_pkg::PH_STOP_A;
                scl_next = 1'b0; sda_next = 1'b0; tick_count_next = '0;
            end
            else
            begin
                ack_wait_count_next = ack_wait_count_reg + 8'd1;
            end
        end
        else
        begin
            tick_count_next = tick_inc;
            ended = (tick_inc >= hold_len);
        end

        // Advance to the next phase when the hold runs out
        if (ended)
        begin
            tick_count_next = '0;
            case (phase_reg)
                i2cbm_pkg::PH_START_A:
                begin
                    phase_next = i2cbm_pkg::PH_START_B; scl_next = 1'b1; sda_next = 1'b0;
                end
                i2cbm_pkg::PH_START_B:
                begin
                    tick_count_next = tick_inc;
                    scl_next = 1'b0; phase_next = i2cbm_pkg::PH_IDLE; done_next = 1'b1;
                end
                i2cbm_pkg::PH_STOP_A:
                begin
                    phase_next = i2cbm_pkg::PH_STOP_B; scl_next = 1'b1; sda_next = 1'b1;
                end
                i2cbm_pkg::PH_STOP_B:
                begin
                    tick_count_next = tick_inc;
                    phase_next = i2cbm_pkg::PH_IDLE; done_next = 1'b1;
                end
                i2cbm_pkg::PH_WR_LOW:
                begin
                    phase_next = i2cbm_pkg::PH_WR_HIGH; scl_next = 1'b1;
                end
                i2cbm_pkg::PH_WR_HIGH:
                begin
                    bit_count_next = bit_inc;
                    if (bit_inc >= 4'(i2cbm_pkg::BITS_PER_BYTE))
                    begin
                        phase_next = i2cbm_pkg::PH_ACK_LOW; scl_next = 1'b0; sda_next = 1'b1;
                    end
                    else
                    begin
                        sda_next        = shift_byte_reg[7];
                        shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                        phase_next = i2cbm_pkg::PH_WR_LOW; scl_next = 1'b0;
                    end
                end
                i2cbm_pkg::PH_ACK_LOW:
                begin
                    ack_wait_count_next = '0;
                    phase_next = i2cbm_pkg::PH_ACK_WAIT; scl_next = 1'b1; sda_next = 1'b1;
                end
                i2cbm_pkg::PH_RD_LOW:
                begin
                    phase_next = i2cbm_pkg::PH_RD_HIGH; scl_next = 1'b1; sda_next = 1'b1;
                end
                i2cbm_pkg::PH_RD_HIGH:
                begin
                    shift_byte_next = {shift_byte_reg[6:0], item.sda_sample};
                    bit_count_next  = bit_inc;
                    scl_next = 1'b0;
                    if (bit_inc >= 4'(i2cbm_pkg::BITS_PER_BYTE))
                    begin
                        phase_next = i2cbm_pkg::PH_RA_LOW; sda_next = !ack_choice_reg;
                    end
                    else
                    begin
                        phase_next = i2cbm_pkg::PH_RD_LOW; sda_next = 1'b1;
                    end
                end
                i2cbm_pkg::PH_RA_LOW:
                begin
                    phase_next = i2cbm_pkg::PH_RA_HIGH; scl_next = 1'b1;
                end
                i2cbm_pkg::PH_RA_HIGH:
                begin
                    tick_count_next = tick_inc;
                    read_hold_next = shift_byte_reg;
                    scl_next = 1'b0; phase_next = i2cbm_pkg::PH_IDLE; done_next = 1'b1;
                end
                default:
                begin
                    phase_next = i2cbm_pkg::PH_IDLE; scl_next = 1'b1; sda_next = 1'b1;
                end
            endcase
        end
    end

    // Result fields from the state after this tick
    always_comb
    begin
        result.scl_level    = scl_next;
        result.sda_pull_low = !sda_next;
        result.busy_res     = (phase_next != i2cbm_pkg::PH_IDLE);
        result.done_res     = done_next;
        result.read_data    = read_hold_next;
        result.nack_seen    = nack_flag_next;
    end

    // Update the sequencer state once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= i2cbm_pkg::PH_IDLE;
            bit_count_reg      <= '0;
            tick_count_reg     <= '0;
            ack_wait_count_reg <= '0;
            shift_byte_reg     <= '0;
            scl_reg            <= 1'b1;
            sda_reg            <= 1'b1;
            ack_choice_reg     <= 1'b0;
            nack_flag_reg      <= 1'b0;
            read_hold_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            bit_count_reg      <= bit_count_next;
            tick_count_reg     <= tick_count_next;
            ack_wait_count_reg <= ack_wait_count_next;
            shift_byte_reg     <= shift_byte_next;
            scl_reg            <= scl_next;
            sda_reg            <= sda_next;
            ack_choice_reg     <= ack_choice_next;
            nack_flag_reg      <= nack_flag_next;
            read_hold_reg      <= read_hold_next;
        end
    end

endmodule
